// ===== rtl/core/mlbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-LED blink controller package
// Transaction payload types, function codes and sequencer control types.
// ----------------------------------------------------------------------------
package mlbc_pkg;

  localparam logic [3:0] FUNC_BLINK        = 4'd0;
  localparam logic [3:0] FUNC_CYCLE_BLINK  = 4'd1;
  localparam logic [3:0] FUNC_SET          = 4'd2;
  localparam logic [3:0] FUNC_RESET        = 4'd3;
  localparam logic [3:0] FUNC_FORCED_SET   = 4'd4;
  localparam logic [3:0] FUNC_FORCED_RESET = 4'd5;
  localparam logic [3:0] FUNC_TOGGLE       = 4'd6;
  localparam logic [3:0] FUNC_FORCED_TOG   = 4'd7;
  localparam logic [3:0] FUNC_CLEAR_FORCED = 4'd8;
  localparam logic [3:0] FUNC_TICK         = 4'd9;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_IDX = 1'b1;

  localparam int PinsW = 8;

  typedef struct packed {
    logic [3:0]  func;
    logic [7:0]  led_index;
    logic [23:0] duration;
  } in_t;

  typedef struct packed {
    logic             status;
    logic [PinsW-1:0] led_pins;
  } out_t;

  // Per-LED flag bits kept next to the counters.
  typedef struct packed {
    logic endless;
    logic cycling;
    logic forced;
    logic pin;
  } flags_t;

  // Control from the sequencer to the LED storage.
  typedef struct packed {
    logic upd_en;
    logic tick;
  } ctrl_t;

endpackage

// ===== rtl/core/mlbc_step_unit.sv =====
// ----------------------------------------------------------------------------
// Multi-LED blink controller step unit
// Shared update logic: computes the next state of one LED for a command or
// for one step of a tick walk. One decrementer serves every LED.
// ----------------------------------------------------------------------------
module mlbc_step_unit
  import mlbc_pkg::*;
#(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                   tick_i,
  input  logic [3:0]             func_i,
  input  logic [COUNT_WIDTH-1:0] dur_i,
  input  logic [COUNT_WIDTH-1:0] rem_i,
  input  logic [COUNT_WIDTH-1:0] rld_i,
  input  flags_t                 flags_i,
  output logic [COUNT_WIDTH-1:0] rem_o,
  output logic [COUNT_WIDTH-1:0] rld_o,
  output flags_t                 flags_o
);

  logic active;

  assign active = flags_i.endless | (rem_i != '0);

  always_comb begin
    rem_o   = rem_i;
    rld_o   = rld_i;
    flags_o = flags_i;
    if (tick_i) begin
      if (flags_i.forced) begin
        flags_o.pin = active;
      end else if (active) begin
        if (!flags_i.cycling) flags_o.pin = 1'b1;
        if (!flags_i.endless) rem_o = rem_i - COUNT_WIDTH'(1);
      end else if (flags_i.cycling) begin
        flags_o.pin = ~flags_i.pin;
        rem_o       = rld_i;
      end else begin
        flags_o.pin = 1'b0;
      end
    end else begin
      case (func_i)
        FUNC_BLINK: begin
          flags_o.cycling = 1'b0;
          flags_o.endless = 1'b0;
          rem_o           = dur_i;
        end
        FUNC_CYCLE_BLINK: begin
          flags_o.cycling = 1'b1;
          flags_o.endless = 1'b0;
          rem_o           = dur_i >> 1;
          rld_o           = dur_i >> 1;
        end
        FUNC_SET, FUNC_FORCED_SET: begin
          flags_o.forced  = flags_i.forced | (func_i == FUNC_FORCED_SET);
          flags_o.cycling = 1'b0;
          flags_o.endless = 1'b1;
          rem_o           = '0;
        end
        FUNC_RESET, FUNC_FORCED_RESET: begin
          flags_o.forced  = flags_i.forced | (func_i == FUNC_FORCED_RESET);
          flags_o.cycling = 1'b0;
          flags_o.endless = 1'b0;
          rem_o           = '0;
        end
        FUNC_TOGGLE, FUNC_FORCED_TOG: begin
          flags_o.forced  = flags_i.forced | (func_i == FUNC_FORCED_TOG);
          flags_o.cycling = 1'b0;
          flags_o.endless = ~active;
          rem_o           = '0;
        end
        FUNC_CLEAR_FORCED: begin
          flags_o.forced = 1'b0;
        end
        default: begin
          flags_o = flags_i;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/mlbc_seq.sv =====
// ----------------------------------------------------------------------------
// Multi-LED blink controller sequencer
// Takes input transactions, walks the LEDs for a tick or applies a single
// command, and holds the result transaction in an output register.
// ----------------------------------------------------------------------------
module mlbc_seq
  import mlbc_pkg::*;
#(
  parameter int LED_COUNT = 8,
  localparam int IdxW     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  input  logic [PinsW-1:0] pins_i,
  output ctrl_t            ctrl_o,
  output logic [IdxW-1:0]  idx_o,
  output in_t              req_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_CMD  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  in_t           req_q, req_d;
  out_t          out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic          in_fire;
  logic          idx_ok;
  logic          is_cmd;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign req_o       = req_q;

  assign idx_ok = ({1'b0, in_data_i.led_index} < 9'(LED_COUNT));
  assign is_cmd = (in_data_i.func <= FUNC_CLEAR_FORCED);

  assign ctrl_o.upd_en = (state_q == S_WALK) | (state_q == S_CMD);
  assign ctrl_o.tick   = (state_q == S_WALK);
  assign idx_o = (state_q == S_WALK) ? cnt_q : req_q.led_index[IdxW-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    req_d       = req_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          req_d = in_data_i;
          cnt_d = '0;
          if (in_data_i.func == FUNC_TICK) begin
            state_d = S_WALK;
          end else if (is_cmd && idx_ok) begin
            state_d = S_CMD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_WALK: begin
        cnt_d = cnt_q + IdxW'(1);
        if (cnt_q == IdxW'(LED_COUNT - 1)) state_d = S_DONE;
      end
      S_CMD: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        // Wait here only while the previous result has not been taken.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d.led_pins = pins_i;
          out_d.status = ((req_q.func <= FUNC_CLEAR_FORCED) &&
                          ({1'b0, req_q.led_index} >= 9'(LED_COUNT)))
                         ? STATUS_BAD_IDX : STATUS_OK;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
  end

endmodule

// ===== rtl/core/multi_led_blink_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Multi-LED blink controller
// Command-driven blink, cycle and force control for a bank of LED pins.
// ----------------------------------------------------------------------------
// Usage: each input transaction on in_valid_i/in_ready_o carries one command
// for a single LED or a millisecond tick. Every input transaction produces
// exactly one output transaction on out_valid_o/out_ready_i with the status
// and the pin vector as it stands after the item.
// Order: a command is applied in the command state and its result is
// registered in the done state; a tick first walks the LED state one entry
// per cycle through the single shared step unit and its decrementer. An item
// with a bad index or an unused function code goes straight to the done state.
// Throughput: one item at a time; in_ready_o is high only while idle. A new
// item may be accepted while the previous result still waits in the output
// register; if the receiver stalls, the block finishes the next item and
// then holds until the pending result is taken.
// Reset: all counters and flags clear, so every LED is dark and not forced,
// and no result is pending.
// ----------------------------------------------------------------------------
module multi_led_blink_controller_unit
  import mlbc_pkg::*;
#(
  parameter int LED_COUNT   = 8,
  parameter int COUNT_WIDTH = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int IdxW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  logic [COUNT_WIDTH-1:0] rem_q [LED_COUNT];
  logic [COUNT_WIDTH-1:0] rld_q [LED_COUNT];
  flags_t                 flags_q [LED_COUNT];

  ctrl_t                  ctrl;
  logic [IdxW-1:0]        idx;
  in_t                    req;
  logic [PinsW-1:0]       pins;
  logic [COUNT_WIDTH-1:0] rem_n, rld_n;
  flags_t                 flags_n;

  mlbc_seq #(
    .LED_COUNT (LED_COUNT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .pins_i      (pins),
    .ctrl_o      (ctrl),
    .idx_o       (idx),
    .req_o       (req)
  );

  mlbc_step_unit #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .tick_i  (ctrl.tick),
    .func_i  (req.func),
    .dur_i   (COUNT_WIDTH'(req.duration)),
    .rem_i   (rem_q[idx]),
    .rld_i   (rld_q[idx]),
    .flags_i (flags_q[idx]),
    .rem_o   (rem_n),
    .rld_o   (rld_n),
    .flags_o (flags_n)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        rem_q[i]   <= '0;
        rld_q[i]   <= '0;
        flags_q[i] <= '0;
      end
    end else if (ctrl.upd_en) begin
      rem_q[idx]   <= rem_n;
      rld_q[idx]   <= rld_n;
      flags_q[idx] <= flags_n;
    end
  end

  // Only the first eight LEDs are visible in the result.
  for (genvar g = 0; g < PinsW; g++) begin : g_pins
    if (g < LED_COUNT) begin : g_led
      assign pins[g] = flags_q[g].pin;
    end else begin : g_none
      assign pins[g] = 1'b0;
    end
  end

endmodule
